@@ rtl/best_fit_job_scheduler_assert.svh @@
// ----------------------------------------------------------------------------
// Best-fit job scheduler assertion macros
// Concurrent assertion wrappers that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_JOB_SCHEDULER_ASSERT_SVH
`define BEST_FIT_JOB_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
`define BFJS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("bfjs assertion failed");
`define BFJS_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("bfjs assertion failed");
`else
`define BFJS_ASSERT(lbl, prop)
`define BFJS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ rtl/bfjs_pkg.sv @@
// ----------------------------------------------------------------------------
// Best-fit job scheduler package
// Shared widths, defaults, command and result codes and sequencer states.
// ----------------------------------------------------------------------------
package bfjs_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int NODE_COUNT_DEF  = 16;

	localparam int AMOUNT_W  = 20;
	localparam int NODE_ID_W = 4;
	localparam int PENDING_W = 5;
	localparam int TOTAL_W   = 32;
	localparam int CODE_W    = 2;

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 96;

	localparam logic [AMOUNT_W-1:0] AMOUNT_MAX = '1;
	localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = '1;

	typedef enum logic [CODE_W-1:0] {
		CMD_ADD_JOB = 2'd0,
		CMD_ADD_RES = 2'd1,
		CMD_STEP    = 2'd2
	} cmd_t;

	typedef enum logic [CODE_W-1:0] {
		KIND_ACCEPT = 2'd0,
		KIND_FULL   = 2'd1,
		KIND_ASSIGN = 2'd2,
		KIND_DONE   = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_JOB,
		ST_ACK,
		ST_RES_RD,
		ST_RES_WR,
		ST_JOB_RD,
		ST_SCAN,
		ST_DECIDE,
		ST_DONE
	} state_t;

endpackage

@@ rtl/bfjs_node_table.sv @@
// ----------------------------------------------------------------------------
// Best-fit job scheduler node table
// Free-resource memory with one registered read port and one write port,
// plus a present flag per node held in flip-flops.
// ----------------------------------------------------------------------------
module bfjs_node_table #(
	parameter int NODE_COUNT = bfjs_pkg::NODE_COUNT_DEF,
	parameter int NODE_AW    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [NODE_AW-1:0]            rd_addr,
	output logic [bfjs_pkg::AMOUNT_W-1:0] rd_free,
	output logic                          rd_present,
	input  logic                          wr_en,
	input  logic [NODE_AW-1:0]            wr_addr,
	input  logic [bfjs_pkg::AMOUNT_W-1:0] wr_free
);

	logic [bfjs_pkg::AMOUNT_W-1:0] free_mem [NODE_COUNT];
	logic [NODE_COUNT-1:0]         present_q;
	logic [bfjs_pkg::AMOUNT_W-1:0] rd_free_q;
	logic                          rd_present_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			free_mem[wr_addr] <= wr_free;
		end
		if (rd_en) begin
			rd_free_q <= free_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q    <= '0;
			rd_present_q <= 1'b0;
		end else begin
			if (wr_en) begin
				present_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_present_q <= present_q[rd_addr];
			end
		end
	end

	assign rd_free    = rd_free_q;
	assign rd_present = rd_present_q;

endmodule

@@ rtl/best_fit_job_scheduler.sv @@
// ----------------------------------------------------------------------------
// Best-fit job scheduler
// Keeps an arrival-ordered job queue and a free-resource count per node, and
// on a step command hands each queued job to the tightest node that fits.
//
// The input stream carries one command per item: cmd in tuser, amount and
// node id in tdata. The output stream returns result items: kind in tuser,
// the final result of a command marked by tlast. Add-resources reads the
// node entry, then writes the sum back. A step takes one job at a time: one
// queue read, then a sweep through the node memory, one node per cycle,
// through a single compare unit, then a decision that assigns the job or
// writes it back to the queue. The node memory read port sets the pace of
// the sweep. A command with code 3 is dropped.
// The block takes no item while a command is being worked on. One output
// register holds a result; when the receiver stalls, work waits until it is
// taken. Reset empties the queue, clears every node and both totals; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
`include "best_fit_job_scheduler_assert.svh"

module best_fit_job_scheduler #(
	parameter int QUEUE_DEPTH = bfjs_pkg::QUEUE_DEPTH_DEF,
	parameter int NODE_COUNT  = bfjs_pkg::NODE_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// amount [19:0], node_id [23:20]
	input  logic [bfjs_pkg::S_TDATA_W-1:0] s_tdata,
	// cmd [1:0]
	input  logic [bfjs_pkg::CODE_W-1:0]    s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// chosen_node [3:0], job_amount [23:4], pending_jobs [28:24],
	// assigned_total [60:29], waited_total [92:61], zero [95:93]
	output logic [bfjs_pkg::M_TDATA_W-1:0] m_tdata,
	// kind [1:0]
	output logic [bfjs_pkg::CODE_W-1:0]    m_tuser,
	output logic                           m_tlast
);

	localparam int QCW     = $clog2(QUEUE_DEPTH + 1);
	localparam int QAW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int SCW     = $clog2(NODE_COUNT + 1);
	localparam int NODE_AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int AW      = bfjs_pkg::AMOUNT_W;
	localparam int TW      = bfjs_pkg::TOTAL_W;

	bfjs_pkg::state_t state_q, state_nx;

	logic [AW-1:0]                   amount_q;
	logic [bfjs_pkg::NODE_ID_W-1:0]  node_id_q;
	logic [QCW-1:0]                  count_q, count_nx, total_q, rd_q, wr_q;
	logic [TW-1:0]                   assigned_q, assigned_nx, waited_q, waited_nx;
	logic [SCW-1:0]                  scan_cnt_q;
	logic                            scan_vld_s1;
	logic [NODE_AW-1:0]              scan_idx_s1;
	logic                            found_q;
	logic [NODE_AW-1:0]              best_q;
	logic [AW-1:0]                   best_free_q;
	logic [AW-1:0]                   job_mem [QUEUE_DEPTH];
	logic [AW-1:0]                   job_rdata_q;

	logic                            m_tvalid_q, last_q;
	bfjs_pkg::kind_t                 kind_q;
	logic [bfjs_pkg::NODE_ID_W-1:0]  node_out_q;
	logic [AW-1:0]                   amt_out_q;
	logic [bfjs_pkg::PENDING_W-1:0]  pend_out_q;
	logic [TW-1:0]                   asg_out_q, wait_out_q;

	logic                            accept, out_free, full, last_job, in_range;
	logic                            fits, better, step_adv;
	logic [QCW-1:0]                  rd_inc;
	logic [AW:0]                     res_sum;
	logic [TW:0]                     wait_sum;
	logic [AW-1:0]                   res_base;

	logic                            emit, emit_last;
	bfjs_pkg::kind_t                 emit_kind;
	logic [bfjs_pkg::NODE_ID_W-1:0]  emit_node;
	logic [AW-1:0]                   emit_amt;
	logic                            job_we, job_re, node_re, node_we, scan_re;
	logic [QAW-1:0]                  job_waddr;
	logic [AW-1:0]                   job_wdata;
	logic [NODE_AW-1:0]              node_raddr, node_waddr;
	logic [AW-1:0]                   node_wdata, node_rd_free;
	logic                            node_rd_present;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == bfjs_pkg::ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign full     = (count_q >= QCW'(QUEUE_DEPTH));
	assign rd_inc   = rd_q + QCW'(1);
	assign last_job = (rd_inc >= total_q);
	assign in_range = (32'(s_tdata[23:20]) < 32'(NODE_COUNT));
	assign res_base = node_rd_present ? node_rd_free : '0;
	assign res_sum  = {1'b0, res_base} + {1'b0, amount_q};
	assign wait_sum = {1'b0, waited_q} + (TW + 1)'(wr_q);
	assign fits     = scan_vld_s1 && node_rd_present && (node_rd_free >= job_rdata_q);
	assign better   = !found_q || (node_rd_free < best_free_q);
	assign step_adv = (state_q == bfjs_pkg::ST_DECIDE) && (!found_q || out_free);

	bfjs_node_table #(
		.NODE_COUNT (NODE_COUNT),
		.NODE_AW    (NODE_AW)
	) u_node_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (node_re),
		.rd_addr    (node_raddr),
		.rd_free    (node_rd_free),
		.rd_present (node_rd_present),
		.wr_en      (node_we),
		.wr_addr    (node_waddr),
		.wr_free    (node_wdata)
	);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			bfjs_pkg::ST_IDLE: begin
				if (accept) begin
					case (bfjs_pkg::cmd_t'(s_tuser))
						bfjs_pkg::CMD_ADD_JOB: state_nx = bfjs_pkg::ST_ADD_JOB;
						bfjs_pkg::CMD_ADD_RES: state_nx = in_range ? bfjs_pkg::ST_RES_RD
							: bfjs_pkg::ST_ACK;
						bfjs_pkg::CMD_STEP: state_nx = (count_q == '0) ? bfjs_pkg::ST_DONE
							: bfjs_pkg::ST_JOB_RD;
						default: state_nx = bfjs_pkg::ST_IDLE;
					endcase
				end
			end
			bfjs_pkg::ST_ADD_JOB, bfjs_pkg::ST_ACK, bfjs_pkg::ST_RES_WR,
			bfjs_pkg::ST_DONE: begin
				if (out_free) state_nx = bfjs_pkg::ST_IDLE;
			end
			bfjs_pkg::ST_RES_RD: state_nx = bfjs_pkg::ST_RES_WR;
			bfjs_pkg::ST_JOB_RD: state_nx = bfjs_pkg::ST_SCAN;
			bfjs_pkg::ST_SCAN: begin
				if (scan_cnt_q == SCW'(NODE_COUNT) && !scan_vld_s1) begin
					state_nx = bfjs_pkg::ST_DECIDE;
				end
			end
			bfjs_pkg::ST_DECIDE: begin
				if (step_adv) begin
					state_nx = last_job ? bfjs_pkg::ST_DONE : bfjs_pkg::ST_JOB_RD;
				end
			end
			default: state_nx = bfjs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		emit        = 1'b0;
		emit_last   = 1'b1;
		emit_kind   = bfjs_pkg::KIND_ACCEPT;
		emit_node   = '0;
		emit_amt    = '0;
		job_we      = 1'b0;
		job_re      = 1'b0;
		job_waddr   = count_q[QAW-1:0];
		job_wdata   = amount_q;
		node_re     = 1'b0;
		scan_re     = 1'b0;
		node_raddr  = scan_cnt_q[NODE_AW-1:0];
		node_we     = 1'b0;
		node_waddr  = NODE_AW'(node_id_q);
		node_wdata  = res_sum[AW] ? bfjs_pkg::AMOUNT_MAX : res_sum[AW-1:0];
		count_nx    = count_q;
		assigned_nx = assigned_q;
		waited_nx   = waited_q;
		unique case (state_q)
			bfjs_pkg::ST_ADD_JOB: begin
				emit      = out_free;
				emit_kind = full ? bfjs_pkg::KIND_FULL : bfjs_pkg::KIND_ACCEPT;
				job_we    = out_free && !full;
				if (job_we) count_nx = count_q + QCW'(1);
			end
			bfjs_pkg::ST_ACK: emit = out_free;
			bfjs_pkg::ST_RES_RD: begin
				node_re    = 1'b1;
				node_raddr = NODE_AW'(node_id_q);
			end
			bfjs_pkg::ST_RES_WR: begin
				emit    = out_free;
				node_we = out_free;
			end
			bfjs_pkg::ST_JOB_RD: job_re = 1'b1;
			bfjs_pkg::ST_SCAN: begin
				scan_re = (scan_cnt_q < SCW'(NODE_COUNT));
				node_re = scan_re;
			end
			bfjs_pkg::ST_DECIDE: begin
				if (found_q) begin
					emit        = out_free;
					emit_last   = 1'b0;
					emit_kind   = bfjs_pkg::KIND_ASSIGN;
					emit_node   = bfjs_pkg::NODE_ID_W'(best_q);
					emit_amt    = job_rdata_q;
					node_we     = out_free;
					node_waddr  = best_q;
					node_wdata  = best_free_q - job_rdata_q;
					if (out_free) begin
						count_nx    = count_q - QCW'(1);
						assigned_nx = (assigned_q == bfjs_pkg::TOTAL_MAX) ? assigned_q
							: assigned_q + TW'(1);
					end
				end else begin
					job_we    = 1'b1;
					job_waddr = wr_q[QAW-1:0];
					job_wdata = job_rdata_q;
				end
			end
			bfjs_pkg::ST_DONE: begin
				emit      = out_free;
				emit_kind = bfjs_pkg::KIND_DONE;
				count_nx  = wr_q;
				if (out_free) begin
					waited_nx = wait_sum[TW] ? bfjs_pkg::TOTAL_MAX : wait_sum[TW-1:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (job_we) begin
			job_mem[job_waddr] <= job_wdata;
		end
		if (job_re) begin
			job_rdata_q <= job_mem[rd_q[QAW-1:0]];
		end
		if (accept) begin
			amount_q  <= s_tdata[19:0];
			node_id_q <= s_tdata[23:20];
		end
		scan_idx_s1 <= scan_cnt_q[NODE_AW-1:0];
		if (fits && better) begin
			best_q      <= scan_idx_s1;
			best_free_q <= node_rd_free;
		end
		if (emit) begin
			kind_q     <= emit_kind;
			last_q     <= emit_last;
			node_out_q <= emit_node;
			amt_out_q  <= emit_amt;
			pend_out_q <= bfjs_pkg::PENDING_W'(count_nx);
			asg_out_q  <= assigned_nx;
			wait_out_q <= waited_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bfjs_pkg::ST_IDLE;
			count_q     <= '0;
			total_q     <= '0;
			rd_q        <= '0;
			wr_q        <= '0;
			assigned_q  <= '0;
			waited_q    <= '0;
			scan_cnt_q  <= '0;
			scan_vld_s1 <= 1'b0;
			found_q     <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q     <= state_nx;
			count_q     <= count_nx;
			assigned_q  <= assigned_nx;
			waited_q    <= waited_nx;
			scan_vld_s1 <= scan_re;
			if (accept) begin
				total_q <= count_q;
				rd_q    <= '0;
				wr_q    <= '0;
			end
			if (state_q == bfjs_pkg::ST_JOB_RD) begin
				scan_cnt_q <= '0;
				found_q    <= 1'b0;
			end else begin
				if (scan_re) scan_cnt_q <= scan_cnt_q + SCW'(1);
				if (fits && better) found_q <= 1'b1;
			end
			if (step_adv) begin
				rd_q <= rd_inc;
				if (!found_q) wr_q <= wr_q + QCW'(1);
			end
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {3'b000, wait_out_q, asg_out_q, pend_out_q, amt_out_q, node_out_q};

	`BFJS_ASSERT(a_last_marks_final, m_tvalid |-> (m_tlast == (m_tuser != bfjs_pkg::KIND_ASSIGN)))
	`BFJS_ASSERT(a_count_bounded, count_q <= QCW'(QUEUE_DEPTH))
	`BFJS_ASSERT(a_compaction_order, wr_q <= rd_q)
	`BFJS_ASSERT(a_assigned_monotonic, assigned_q >= $past(assigned_q))
	`BFJS_ASSERT(a_best_fits_job, found_q |-> (best_free_q >= job_rdata_q))

endmodule

@@ tb/best_fit_job_scheduler_tb.sv @@
// ----------------------------------------------------------------------------
// Best-fit job scheduler testbench
// Drives add-job, add-resources and step commands into the input stream in
// random bursts, with the output stream stalling on a pattern of its own.
// A directed table covers the extremes, the full queue, ties between nodes
// and jobs that fit nowhere; random commands follow. Every result item is
// checked against a scheduler predictor kept inside the testbench.
// ----------------------------------------------------------------------------
module best_fit_job_scheduler_tb;

	import bfjs_pkg::*;

	localparam int                QDEPTH      = QUEUE_DEPTH_DEF;
	localparam int                NNODES      = NODE_COUNT_DEF;
	localparam int                NO_NODE     = -1;
	localparam logic [CODE_W-1:0] CMD_UNUSED  = 2'd3;
	localparam int                RAND_ITEMS  = 190;
	localparam int                DRAIN_WAIT  = 400;
	localparam int                IDLE_LIMIT  = 5000;
	localparam int                MAX_REPORTS = 10;
	localparam int                DIR_ROWS    = 25;

	typedef struct packed {
		kind_t                kind;
		logic [NODE_ID_W-1:0] node;
		logic [AMOUNT_W-1:0]  amount;
		logic [PENDING_W-1:0] pending;
		logic [TOTAL_W-1:0]   assigned_total;
		logic [TOTAL_W-1:0]   waited_total;
		logic                 last;
	} sched_res_t;

	typedef struct {
		logic [CODE_W-1:0]    cmd;
		logic [AMOUNT_W-1:0]  amount;
		logic [NODE_ID_W-1:0] node;
		int                   reps;
		bit                   typed;
		sched_res_t           res;
	} stim_row_t;

	localparam sched_res_t NO_RES = '{KIND_ACCEPT, 4'd0, 20'd0, 5'd0, 32'd0, 32'd0, 1'b0};

	stim_row_t dir_rows [DIR_ROWS] = '{
		'{CMD_STEP,    20'd0,      4'd0,  1,  1'b1,
			'{KIND_DONE,   4'd0, 20'd0, 5'd0,  32'd0, 32'd0, 1'b1}},
		'{CMD_ADD_JOB, 20'd0,      4'd0,  1,  1'b1,
			'{KIND_ACCEPT, 4'd0, 20'd0, 5'd1,  32'd0, 32'd0, 1'b1}},
		'{CMD_ADD_JOB, 20'hFFFFF,  4'd0,  1,  1'b1,
			'{KIND_ACCEPT, 4'd0, 20'd0, 5'd2,  32'd0, 32'd0, 1'b1}},
		'{CMD_STEP,    20'd0,      4'd0,  1,  1'b1,
			'{KIND_DONE,   4'd0, 20'd0, 5'd2,  32'd0, 32'd2, 1'b1}},
		'{CMD_ADD_RES, 20'd0,      4'd15, 1,  1'b1,
			'{KIND_ACCEPT, 4'd0, 20'd0, 5'd2,  32'd0, 32'd2, 1'b1}},
		'{CMD_STEP,    20'd0,      4'd0,  1,  1'b0, NO_RES},
		'{CMD_ADD_RES, 20'hFFFFF,  4'd0,  1,  1'b0, NO_RES},
		'{CMD_ADD_RES, 20'hFFFFF,  4'd0,  1,  1'b0, NO_RES},
		'{CMD_ADD_RES, 20'hFFFFF,  4'd3,  1,  1'b0, NO_RES},
		'{CMD_STEP,    20'd0,      4'd0,  1,  1'b0, NO_RES},
		'{CMD_ADD_JOB, 20'd5,      4'd0,  16, 1'b0, NO_RES},
		'{CMD_ADD_JOB, 20'd7,      4'd0,  1,  1'b1,
			'{KIND_FULL,   4'd0, 20'd0, 5'd16, 32'd2, 32'd3, 1'b1}},
		'{CMD_UNUSED,  20'hFFFFF,  4'd15, 1,  1'b0, NO_RES},
		'{CMD_STEP,    20'd0,      4'd0,  1,  1'b0, NO_RES},
		'{CMD_ADD_RES, 20'd10,     4'd7,  1,  1'b0, NO_RES},
		'{CMD_ADD_RES, 20'd12,     4'd2,  1,  1'b0, NO_RES},
		'{CMD_ADD_JOB, 20'd11,     4'd0,  1,  1'b0, NO_RES},
		'{CMD_ADD_JOB, 20'd10,     4'd0,  1,  1'b0, NO_RES},
		'{CMD_ADD_JOB, 20'd13,     4'd0,  1,  1'b0, NO_RES},
		'{CMD_STEP,    20'd0,      4'd0,  1,  1'b0, NO_RES},
		'{CMD_ADD_JOB, 20'hFFFFF,  4'd0,  1,  1'b0, NO_RES},
		'{CMD_ADD_JOB, 20'd1,      4'd0,  1,  1'b0, NO_RES},
		'{CMD_STEP,    20'd0,      4'd0,  1,  1'b0, NO_RES},
		'{CMD_ADD_RES, 20'hFFFFF,  4'd9,  1,  1'b0, NO_RES},
		'{CMD_STEP,    20'd0,      4'd0,  1,  1'b0, NO_RES}
	};

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [CODE_W-1:0]    s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [CODE_W-1:0]    m_tuser;
	logic                 m_tlast;

	logic [AMOUNT_W-1:0]  pend_amt [QDEPTH];
	logic [PENDING_W-1:0] pend_len;
	logic [AMOUNT_W-1:0]  node_cap [NNODES];
	logic                 node_up  [NNODES];
	logic [TOTAL_W-1:0]   n_assigned;
	logic [TOTAL_W-1:0]   n_waited;

	sched_res_t due_results [$];
	int         err_count = 0;
	int         idle_cycles = 0;
	int         burst_left = 0;
	int         rdy_run = 0;
	logic       rdy_level = 1'b1;

	best_fit_job_scheduler u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int tightest_node(input logic [AMOUNT_W-1:0] need);
		int                  best;
		logic [AMOUNT_W-1:0] best_cap;
		best     = NO_NODE;
		best_cap = '0;
		for (int n = 0; n < NNODES; n++) begin
			if (node_up[n] && node_cap[n] >= need && (best == NO_NODE || node_cap[n] < best_cap)) begin
				best     = n;
				best_cap = node_cap[n];
			end
		end
		return best;
	endfunction

	task automatic push_result(input kind_t kind, input int node, input logic [AMOUNT_W-1:0] amt,
			input logic last);
		sched_res_t r;
		r.kind           = kind;
		r.node           = node[NODE_ID_W-1:0];
		r.amount         = amt;
		r.pending        = pend_len;
		r.assigned_total = n_assigned;
		r.waited_total   = n_waited;
		r.last           = last;
		due_results.push_back(r);
	endtask

	task automatic run_scheduler(input logic [CODE_W-1:0] cmd, input logic [AMOUNT_W-1:0] amt,
			input logic [NODE_ID_W-1:0] nid);
		logic [AMOUNT_W:0]    sum;
		logic [AMOUNT_W-1:0]  need;
		int                   n;
		int                   wr;
		int                   total;
		case (cmd)
			CMD_ADD_JOB: begin
				if (pend_len >= QDEPTH) begin
					push_result(KIND_FULL, 0, '0, 1'b1);
				end else begin
					pend_amt[pend_len] = amt;
					pend_len++;
					push_result(KIND_ACCEPT, 0, '0, 1'b1);
				end
			end
			CMD_ADD_RES: begin
				sum           = {1'b0, node_cap[nid]} + {1'b0, amt};
				node_cap[nid] = sum > AMOUNT_MAX ? AMOUNT_MAX : sum[AMOUNT_W-1:0];
				node_up[nid]  = 1'b1;
				push_result(KIND_ACCEPT, 0, '0, 1'b1);
			end
			CMD_STEP: begin
				wr    = 0;
				total = pend_len;
				for (int rd = 0; rd < total; rd++) begin
					need = pend_amt[rd];
					n    = tightest_node(need);
					if (n == NO_NODE) begin
						pend_amt[wr] = need;
						wr++;
					end else begin
						node_cap[n] -= need;
						if (n_assigned != TOTAL_MAX)
							n_assigned++;
						pend_len--;
						push_result(KIND_ASSIGN, n, need, 1'b0);
					end
				end
				pend_len = PENDING_W'(wr);
				if (n_waited > TOTAL_MAX - pend_len)
					n_waited = TOTAL_MAX;
				else
					n_waited += pend_len;
				push_result(KIND_DONE, 0, '0, 1'b1);
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_item(input logic [CODE_W-1:0] cmd, input logic [AMOUNT_W-1:0] amt,
			input logic [NODE_ID_W-1:0] nid, input bit typed, input sched_res_t res);
		s_tvalid <= 1'b1;
		s_tdata  <= {nid, amt};
		s_tuser  <= cmd;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		run_scheduler(cmd, amt, nid);
		if (typed) begin
			void'(due_results.pop_back());
			due_results.push_back(res);
		end
	endtask

	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
	endtask

	function automatic logic [AMOUNT_W-1:0] pick_amount(input bit for_node);
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return AMOUNT_MAX;
		if (r == 2)
			return AMOUNT_W'($urandom());
		return for_node ? AMOUNT_W'($urandom_range(100, 8000))
			: AMOUNT_W'($urandom_range(1, 2000));
	endfunction

	always @(posedge clk) begin
		if (rdy_run == 0) begin
			rdy_run   = $urandom_range(1, 24);
			rdy_level = ($urandom_range(0, 3) != 0);
		end
		rdy_run--;
		m_tready <= rdy_level;
	end

	always @(posedge clk) begin
		sched_res_t got;
		sched_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind           = kind_t'(m_tuser);
			got.node           = m_tdata[3:0];
			got.amount         = m_tdata[23:4];
			got.pending        = m_tdata[28:24];
			got.assigned_total = m_tdata[60:29];
			got.waited_total   = m_tdata[92:61];
			got.last           = m_tlast;
			if (due_results.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display("unexpected result item: kind %0d node %0d amount %0d", got.kind,
						got.node, got.amount);
			end else begin
				want = due_results.pop_front();
				if (got !== want) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$display({"mismatch: kind %0d/%0d node %0d/%0d amount %0d/%0d ",
							"pending %0d/%0d assigned %0d/%0d waited %0d/%0d last %0d/%0d ",
							"(expected/actual)"},
							want.kind, got.kind, want.node, got.node, want.amount, got.amount,
							want.pending, got.pending, want.assigned_total, got.assigned_total,
							want.waited_total, got.waited_total, want.last, got.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		logic [CODE_W-1:0]    cmd;
		logic [AMOUNT_W-1:0]  amt;
		logic [NODE_ID_W-1:0] nid;
		int                   sel;
		int                   rand_sent;
		pend_len   = '0;
		n_assigned = '0;
		n_waited   = '0;
		for (int i = 0; i < QDEPTH; i++)
			pend_amt[i] = '0;
		for (int i = 0; i < NNODES; i++) begin
			node_cap[i] = '0;
			node_up[i]  = 1'b0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			for (int k = 0; k < dir_rows[i].reps; k++) begin
				send_item(dir_rows[i].cmd, dir_rows[i].amount, dir_rows[i].node, dir_rows[i].typed,
					dir_rows[i].res);
				pace();
			end
		end

		rand_sent = 0;
		while (rand_sent < RAND_ITEMS) begin
			sel = $urandom_range(0, 99);
			if (sel < 40)
				cmd = CMD_ADD_JOB;
			else if (sel < 70)
				cmd = CMD_ADD_RES;
			else if (sel < 95)
				cmd = CMD_STEP;
			else
				cmd = CMD_UNUSED;
			amt = pick_amount(cmd == CMD_ADD_RES);
			nid = NODE_ID_W'($urandom_range(0, NNODES - 1));
			send_item(cmd, amt, nid, 1'b0, NO_RES);
			if (cmd != CMD_UNUSED)
				rand_sent++;
			pace();
		end

		s_tvalid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ best_fit_job_scheduler.f @@
+incdir+rtl
rtl/bfjs_pkg.sv
rtl/bfjs_node_table.sv
rtl/best_fit_job_scheduler.sv
tb/best_fit_job_scheduler_tb.sv
